### hw/rtl/pcg_pkg.sv
// Package for the bounded PCG32 generator.
// Holds the LCG multiplier, register indexes, controller/datapath structs and output function.
// No dependencies.
package pcg_pkg;

	localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
	localparam logic [31:0] PCG_MULT_LO = PCG_MULT[31:0];
	localparam logic [31:0] PCG_MULT_HI = PCG_MULT[63:32];

	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SEED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INCR = 8'd1;

	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned CNT_W = 5;

	localparam logic [CNT_W-1:0] MUL_PH_LL = 5'd0;
	localparam logic [CNT_W-1:0] MUL_PH_LH = 5'd1;
	localparam logic [CNT_W-1:0] MUL_PH_HL = 5'd2;
	localparam logic [CNT_W-1:0] MUL_PH_ACC = 5'd3;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} pcg_cmd_t;

	typedef struct packed {
		logic last_step;
	} pcg_status_t;

	function automatic logic [31:0] xsh_rr(input logic [63:0] s);
		logic [63:0] mix;
		logic [31:0] x;
		logic [4:0] r;
		logic [63:0] dbl;
		mix = (s >> 18) ^ s;
		x = mix[58:27];
		r = s[63:59];
		dbl = {x, x} >> r;
		return dbl[31:0];
	endfunction

endpackage

### hw/rtl/pcg_datapath.sv
// Datapath of the bounded PCG32 generator: state, increment, multiword LCG multiply,
// radix-2 remainder unit and output register. Driven by pcg_ctrl; uses pcg_pkg.
module pcg_datapath
	import pcg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic [31:0]          range_start,
	input  logic [31:0]          range_end,
	input  pcg_cmd_t             cmd,
	output pcg_status_t          status,
	output logic [31:0]          random_value
);

	logic [63:0] state_q;
	logic [63:0] incr_q;
	logic [63:0] old_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] span_q;
	logic [31:0] start_q;
	logic [31:0] raw_q;
	logic [31:0] dvd_q;
	logic [31:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] out_q;

	logic [32:0] shifted;
	logic [32:0] diff;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] reduced;

	always_comb begin
		shifted = {rem_q, dvd_q[31]};
		diff = shifted - {1'b0, span_q};
		case (cnt_q)
			MUL_PH_LL: begin
				mul_a = old_q[31:0];
				mul_b = PCG_MULT_LO;
			end
			MUL_PH_LH: begin
				mul_a = old_q[31:0];
				mul_b = PCG_MULT_HI;
			end
			default: begin
				mul_a = old_q[63:32];
				mul_b = PCG_MULT_LO;
			end
		endcase
		reduced = (span_q == 32'd0) ? raw_q : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= 64'd0;
			incr_q <= 64'd1;
		end else begin
			if (cfg_we && cfg_index == REG_SEED) begin
				state_q <= cfg_data;
			end else if (cmd.finish) begin
				state_q <= acc_q + (incr_q | 64'd1);
			end
			if (cfg_we && cfg_index == REG_INCR) begin
				incr_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			old_q <= state_q;
			raw_q <= xsh_rr(state_q);
			dvd_q <= xsh_rr(state_q);
			rem_q <= 32'd0;
			span_q <= range_end - range_start + 32'd1;
			start_q <= range_start;
			cnt_q <= '0;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= diff[32] ? shifted[31:0] : diff[31:0];
			cnt_q <= cnt_q + 1'b1;
			prod_q <= 64'(mul_a) * 64'(mul_b);
			case (cnt_q)
				MUL_PH_LH: acc_q <= prod_q;
				MUL_PH_HL: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				MUL_PH_ACC: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				default: acc_q <= acc_q;
			endcase
		end
		if (cmd.finish) begin
			out_q <= reduced + start_q;
		end
	end

	assign status.last_step = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign random_value = out_q;

endmodule

### hw/rtl/pcg_ctrl.sv
// Controller of the bounded PCG32 generator: sequences load, remainder steps and result
// hand-off, and owns the input ready and output valid. Uses pcg_pkg.
module pcg_ctrl
	import pcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  pcg_status_t status,
	output pcg_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic can_finish;

	assign in_ready = (state_q == ST_IDLE);
	assign can_finish = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.step = (state_q == ST_RUN);
		cmd.finish = can_finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (can_finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (status.last_step) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (can_finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/pcg32_bounded_random.sv
// Bounded PCG32 generator: one request in, one value in [start, end] out.
// A request is loaded, then the radix-2 unit runs 32 remainder steps, then the result goes
// into the output register once any earlier result has been taken; a new request is accepted
// only after that hand-off. The next request is taken while a result waits.
// Reset clears the generator state to zero and the increment to one; a seed write loads the state.
module pcg32_bounded_random
	import pcg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [63:0]          s_axis_tdata,  // range_start [31:0], range_end [63:32]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,  // random_value [31:0]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	pcg_cmd_t cmd;
	pcg_status_t status;

	assign cfg_ready = 1'b1;

	pcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	pcg_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.range_start  (s_axis_tdata[31:0]),
		.range_end    (s_axis_tdata[63:32]),
		.cmd          (cmd),
		.status       (status),
		.random_value (m_axis_tdata)
	);

endmodule
